// ===== rtl/spifrc_pkg.sv =====
// Shared types and constants for the SPI frame receive checker.
package spifrc_pkg;

	typedef enum logic [3:0] {
		PH_MK_HI  = 4'd0,
		PH_MK_LO  = 4'd1,
		PH_RS_HI  = 4'd2,
		PH_RS_LO  = 4'd3,
		PH_ST_HI  = 4'd4,
		PH_ST_LO  = 4'd5,
		PH_BODY   = 4'd6,
		PH_TL_HI  = 4'd7,
		PH_TL_LO  = 4'd8,
		PH_BAD_HI = 4'd9,
		PH_BAD_LO = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY      = 3'd0,
		ST_GOOD      = 3'd1,
		ST_RETRY     = 3'd2,
		ST_BAD_MARK  = 3'd3,
		ST_NOT_READY = 3'd4,
		ST_ZERO_LEN  = 3'd5,
		ST_BAD_START = 3'd6,
		ST_BAD_TAIL  = 3'd7
	} status_t;

	localparam int unsigned NUM_COUNTERS = 8;
	localparam int unsigned CIDX_BITS    = 3;

	typedef enum logic [CIDX_BITS-1:0] {
		C_XFER     = 3'd0,
		C_MARKER   = 3'd1,
		C_CTR      = 3'd2,
		C_TAIL     = 3'd3,
		C_LEN      = 3'd4,
		C_READY    = 3'd5,
		C_START    = 3'd6,
		C_GOOD     = 3'd7
	} cidx_t;

	localparam logic [15:0] MARKER_WORD = 16'h0001;
	localparam logic [15:0] START_WORD  = 16'h0002;
	localparam logic [15:0] TAIL_WORD   = 16'h55AA;
	localparam logic [3:0]  READY_CODE  = 4'h1;

	typedef struct packed {
		logic  en;
		cidx_t idx;
	} bump_t;

endpackage

// ===== rtl/spifrc_parser.sv =====
// Frame parser: phase tracking, response checks and per-byte result.
module spifrc_parser #(
	parameter int LENGTH_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic                     op,
	input  logic [7:0]               rx_byte,
	output logic [7:0]               res_byte,
	output logic                     res_pvalid,
	output spifrc_pkg::status_t      res_status,
	output spifrc_pkg::bump_t        bump
);
	import spifrc_pkg::*;

	phase_t                 phase_q, phase_d;
	logic                   second_q, second_d;
	logic [7:0]             hi_q, hi_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [LENGTH_BITS-1:0] seen_q, seen_d;
	logic                   sbad_q, sbad_d;
	logic [15:0]            word;
	logic [LENGTH_BITS-1:0] seen_inc;

	assign word     = {hi_q, rx_byte};
	assign seen_inc = seen_q + LENGTH_BITS'(1);

	always_comb begin
		phase_d    = phase_q;
		second_d   = second_q;
		hi_d       = hi_q;
		len_d      = len_q;
		seen_d     = seen_q;
		sbad_d     = sbad_q;
		res_byte   = 8'd0;
		res_pvalid = 1'b0;
		res_status = ST_BUSY;
		bump       = '{en: 1'b0, idx: C_XFER};
		if (!op) begin
			case (phase_q)
				PH_MK_LO: begin
					if (word == MARKER_WORD) begin
						phase_d = PH_RS_HI;
					end else begin
						bump    = '{en: 1'b1, idx: C_MARKER};
						phase_d = PH_BAD_HI;
					end
				end
				PH_RS_HI, PH_ST_HI, PH_TL_HI: begin
					hi_d    = rx_byte;
					phase_d = phase_t'(phase_q + 4'd1);
				end
				PH_RS_LO: begin
					if (word[15:12] != READY_CODE) begin
						phase_d = PH_MK_HI;
						if (second_q) begin
							bump       = '{en: 1'b1, idx: C_READY};
							second_d   = 1'b0;
							res_status = ST_NOT_READY;
						end else begin
							second_d   = 1'b1;
							res_status = ST_RETRY;
						end
					end else if (word[LENGTH_BITS-1:0] == '0) begin
						bump       = '{en: 1'b1, idx: C_LEN};
						phase_d    = PH_MK_HI;
						second_d   = 1'b0;
						res_status = ST_ZERO_LEN;
					end else begin
						len_d    = word[LENGTH_BITS-1:0];
						second_d = 1'b0;
						phase_d  = PH_ST_HI;
					end
				end
				PH_BAD_HI: phase_d = PH_BAD_LO;
				PH_BAD_LO: begin
					phase_d    = PH_MK_HI;
					second_d   = !second_q;
					res_status = second_q ? ST_BAD_MARK : ST_RETRY;
				end
				PH_ST_LO: begin
					sbad_d  = (word != START_WORD);
					seen_d  = '0;
					phase_d = PH_BODY;
				end
				PH_BODY: begin
					res_byte   = rx_byte;
					res_pvalid = 1'b1;
					seen_d     = seen_inc;
					if (seen_inc >= len_q)
						phase_d = PH_TL_HI;
				end
				PH_TL_LO: begin
					if (sbad_q) begin
						bump       = '{en: 1'b1, idx: C_START};
						res_status = ST_BAD_START;
					end else if (word != TAIL_WORD) begin
						bump       = '{en: 1'b1, idx: C_TAIL};
						res_status = ST_BAD_TAIL;
					end else begin
						bump       = '{en: 1'b1, idx: C_GOOD};
						res_status = ST_GOOD;
					end
					phase_d  = PH_MK_HI;
					second_d = 1'b0;
				end
				default: begin
					// first marker byte, also taken for unused phase codes
					hi_d    = rx_byte;
					phase_d = PH_MK_LO;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MK_HI;
			second_q <= 1'b0;
			hi_q     <= '0;
			len_q    <= '0;
			seen_q   <= '0;
			sbad_q   <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			second_q <= second_d;
			hi_q     <= hi_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			sbad_q   <= sbad_d;
		end
	end

endmodule

// ===== rtl/spi_frame_receive_checker_top.sv =====
// Top level of the SPI frame receive checker: handshake, counters, result register.
//
// Each transaction carries one link byte (op 0) or a counter read (op 1) and
// yields exactly one result in the cycle after acceptance. The block takes
// one transaction per clock while in_stall is low: the parser updates its
// state at the accept edge and the result lands in a single output register,
// which reloads in the same cycle it is taken, so in_stall rises only while
// that register holds a result the sink is stalling. Eight COUNTER_BITS-wide
// statistics counters are read through counter_value (low 32 bits); a read
// sees every byte accepted before it.
module spi_frame_receive_checker_top #(
	parameter int LENGTH_BITS  = 12,
	parameter int COUNTER_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	input  logic [2:0]  counter_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic [2:0]  status,
	output logic [31:0] counter_value
);
	import spifrc_pkg::*;

	logic                    take;
	logic [7:0]              res_byte;
	logic                    res_pvalid;
	status_t                 res_status;
	bump_t                   bump;
	logic [COUNTER_BITS-1:0] cnt_q [NUM_COUNTERS];
	logic                    out_valid_q;
	logic [7:0]              pbyte_q;
	logic                    pvalid_q;
	logic [2:0]              status_q;
	logic [31:0]             cval_q;

	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	spifrc_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.op         (op),
		.rx_byte    (rx_byte),
		.res_byte   (res_byte),
		.res_pvalid (res_pvalid),
		.res_status (res_status),
		.bump       (bump)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++)
				cnt_q[i] <= '0;
		end else if (take && bump.en) begin
			cnt_q[bump.idx] <= cnt_q[bump.idx] + COUNTER_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pbyte_q  <= res_byte;
			pvalid_q <= res_pvalid;
			status_q <= res_status;
			cval_q   <= op ? 32'(cnt_q[counter_index]) : 32'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = pbyte_q;
	assign payload_valid = pvalid_q;
	assign status        = status_q;
	assign counter_value = cval_q;

endmodule

// ===== bench/frame_result_checker.sv =====
`timescale 1ns / 1ps
// Bench opcode package and the result checker that models the SPI frame receive checker.
package frame_bench_pkg;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

endpackage

module frame_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	input  logic [2:0]  counter_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  payload_byte,
	input  logic        payload_valid,
	input  logic [2:0]  status,
	input  logic [31:0] counter_value,
	output int          fail_count,
	output int          pending,
	output int          checked,
	output logic [7:0]  status_seen
);

	import spifrc_pkg::*;
	import frame_bench_pkg::*;

	typedef struct packed {
		logic [7:0]  pbyte;
		logic        pvalid;
		status_t     st;
		logic [31:0] cval;
	} frame_result_t;

	frame_result_t due_results[$];
	frame_result_t want;
	frame_result_t fresh;

	// parser copy
	phase_t      link_phase;
	logic        retry_armed;
	logic [15:0] resp_word;
	logic [11:0] body_len;
	logic [11:0] body_count;
	logic        start_bad;
	logic [7:0]  tail_hi;
	logic [31:0] stat_cnt [NUM_COUNTERS];

	function automatic void bump(cidx_t idx);
		stat_cnt[idx] = stat_cnt[idx] + 32'd1;
	endfunction

	function automatic void end_sequence();
		link_phase  = PH_MK_HI;
		retry_armed = 1'b0;
	endfunction

	// first failure arms a retry, second one ends the sequence
	function automatic status_t fail_attempt(status_t final_st);
		if (!retry_armed) begin
			link_phase  = PH_MK_HI;
			retry_armed = 1'b1;
			return ST_RETRY;
		end
		end_sequence();
		return final_st;
	endfunction

	function automatic frame_result_t parse_link_txn(logic o, logic [7:0] b, logic [2:0] ci);
		frame_result_t r;
		logic [15:0]   w;
		r.pbyte  = 8'h00;
		r.pvalid = 1'b0;
		r.st     = ST_BUSY;
		r.cval   = 32'h0;
		w = {resp_word[7:0], b};
		if (o == OP_READ) begin
			r.cval = stat_cnt[ci];
		end else begin
			case (link_phase)
				PH_MK_LO: begin
					if (w == MARKER_WORD) begin
						link_phase = PH_RS_HI;
					end else begin
						bump(C_MARKER);
						link_phase = PH_BAD_HI;
					end
				end
				PH_RS_HI: begin
					resp_word  = {8'h00, b};
					link_phase = PH_RS_LO;
				end
				PH_RS_LO: begin
					resp_word = w;
					if (w[15:12] != READY_CODE) begin
						if (retry_armed)
							bump(C_READY);
						r.st = fail_attempt(ST_NOT_READY);
					end else if (w[11:0] == 12'd0) begin
						bump(C_LEN);
						end_sequence();
						r.st = ST_ZERO_LEN;
					end else begin
						body_len    = w[11:0];
						retry_armed = 1'b0;
						link_phase  = PH_ST_HI;
					end
				end
				PH_BAD_HI: link_phase = PH_BAD_LO;
				PH_BAD_LO: r.st = fail_attempt(ST_BAD_MARK);
				PH_ST_HI: begin
					resp_word  = {8'h00, b};
					link_phase = PH_ST_LO;
				end
				PH_ST_LO: begin
					start_bad  = (w != START_WORD);
					body_count = 12'd0;
					link_phase = PH_BODY;
				end
				PH_BODY: begin
					r.pbyte    = b;
					r.pvalid   = 1'b1;
					body_count = body_count + 12'd1;
					if (body_count >= body_len)
						link_phase = PH_TL_HI;
				end
				PH_TL_HI: begin
					tail_hi    = b;
					link_phase = PH_TL_LO;
				end
				PH_TL_LO: begin
					if (start_bad) begin
						bump(C_START);
						r.st = ST_BAD_START;
					end else if ({tail_hi, b} != TAIL_WORD) begin
						bump(C_TAIL);
						r.st = ST_BAD_TAIL;
					end else begin
						bump(C_GOOD);
						r.st = ST_GOOD;
					end
					end_sequence();
				end
				default: begin
					// first marker byte, also any unknown phase
					resp_word  = {8'h00, b};
					link_phase = PH_MK_LO;
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_phase  = PH_MK_HI;
			retry_armed = 1'b0;
			resp_word   = 16'h0;
			body_len    = 12'h0;
			body_count  = 12'h0;
			start_bad   = 1'b0;
			tail_hi     = 8'h0;
			for (int i = 0; i < NUM_COUNTERS; i++)
				stat_cnt[i] = 32'h0;
			due_results.delete();
			fail_count  = 0;
			pending     = 0;
			checked     = 0;
			status_seen = 8'h00;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected transaction, status %0d payload %02h",
						$time, status, payload_byte);
				end else begin
					want = due_results.pop_front();
					checked++;
					status_seen[status] = 1'b1;
					if (payload_byte !== want.pbyte) begin
						fail_count++;
						$display("%0t: payload_byte expected %02h, got %02h",
							$time, want.pbyte, payload_byte);
					end
					if (payload_valid !== want.pvalid) begin
						fail_count++;
						$display("%0t: payload_valid expected %0d, got %0d",
							$time, want.pvalid, payload_valid);
					end
					if (status !== want.st) begin
						fail_count++;
						$display("%0t: status expected %0d, got %0d",
							$time, want.st, status);
					end
					if (counter_value !== want.cval) begin
						fail_count++;
						$display("%0t: counter_value expected %08h, got %08h",
							$time, want.cval, counter_value);
					end
				end
			end
			if (in_valid && !in_stall) begin
				fresh = parse_link_txn(op, rx_byte, counter_index);
				due_results.push_back(fresh);
			end
			pending = due_results.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, link byte stimulus, sink stalls and the final verdict.
module tb_top;

	import spifrc_pkg::*;
	import frame_bench_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [7:0]  rx_byte;
	logic [2:0]  counter_index;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic [2:0]  status;
	logic [31:0] counter_value;

	int         fail_count;
	int         pending;
	int         checked;
	logic [7:0] status_seen;

	int n_sent    = 0;
	int hold_left = 0;
	int drain     = 0;
	bit src_gaps  = 1'b0;
	bit sink_gaps = 1'b0;

	spi_frame_receive_checker_top uut (.*);

	frame_result_checker chk (.*);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// sink: random stalls, plus long hold-offs counted here
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= sink_gaps && ($urandom_range(0, 99) < 34);
			end
		end
	end

	task automatic send_txn(input logic o, input logic [7:0] b, input logic [2:0] ci);
		while (src_gaps && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		op            <= o;
		rx_byte       <= b;
		counter_index <= ci;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_txn(OP_BYTE, b, 3'($urandom));
	endtask

	task automatic send_word(input logic [15:0] w);
		send_byte(w[15:8]);
		send_byte(w[7:0]);
	endtask

	task automatic send_read();
		send_txn(OP_READ, 8'($urandom), 3'($urandom));
	endtask

	// body and tail only follow a response the block accepts
	task automatic send_frame(input logic [15:0] marker, input logic [15:0] resp,
			input logic [15:0] start_w, input logic [15:0] tail_w);
		send_word(marker);
		send_word(resp);
		if (marker == MARKER_WORD && resp[15:12] == READY_CODE && resp[11:0] != 12'd0) begin
			send_word(start_w);
			for (int i = 0; i < resp[11:0]; i++) begin
				if ($urandom_range(0, 99) < 5)
					send_read();
				send_byte(8'($urandom));
			end
			send_word(tail_w);
		end
	endtask

	task automatic send_random_sequence();
		int          pick;
		logic [15:0] marker;
		logic [15:0] resp;
		logic [15:0] start_w;
		logic [15:0] tail_w;
		logic [11:0] len;
		logic [3:0]  code;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			send_byte(8'($urandom));
		end else if (pick < 14) begin
			send_read();
		end else begin
			marker = ($urandom_range(0, 99) < 15) ? 16'($urandom) : MARKER_WORD;
			pick = $urandom_range(0, 99);
			if (pick < 8)
				len = 12'd0;
			else if (pick < 12)
				len = 12'($urandom_range(1, 40));
			else
				len = 12'($urandom_range(1, 8));
			code    = ($urandom_range(0, 99) < 15) ? 4'($urandom) : READY_CODE;
			resp    = {code, len};
			start_w = ($urandom_range(0, 99) < 12) ? 16'($urandom) : START_WORD;
			tail_w  = ($urandom_range(0, 99) < 12) ? 16'($urandom) : TAIL_WORD;
			send_frame(marker, resp, start_w, tail_w);
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		op            <= OP_BYTE;
		rx_byte       <= 8'h00;
		counter_index <= 3'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_txn(OP_READ, 8'hFF, C_XFER);
		// bad marker takes the retry, then not ready on the second attempt ends it
		send_word(16'hFFFF);
		send_word(16'h1FFF);
		send_word(MARKER_WORD);
		send_word(16'h2005);
		send_word(MARKER_WORD);
		send_word(16'h1000);
		// bad start word still passes the body through
		send_frame(MARKER_WORD, 16'h1001, 16'hFF02, TAIL_WORD);
		send_txn(OP_READ, 8'h00, C_START);

		while (n_sent < 100)
			send_random_sequence();
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		hold_left = 70;
		while (n_sent < 250)
			send_random_sequence();
		hold_left = 90;
		while (n_sent < 370)
			send_random_sequence();

		send_frame(MARKER_WORD, 16'h1040, START_WORD, TAIL_WORD);
		for (int i = 0; i < NUM_COUNTERS; i++)
			send_txn(OP_READ, 8'($urandom), 3'(i));
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);

		if (pending != 0)
			$display("%0t: %0d results never arrived", $time, pending);
		$display("Sent %0d transactions: directed errors, random frames, a 64-byte frame.",
			n_sent);
		$display("Checked %0d results; status codes seen (7 down to 0): %b",
			checked, status_seen);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/spifrc_pkg.sv
rtl/spifrc_parser.sv
rtl/spi_frame_receive_checker_top.sv
bench/frame_result_checker.sv
bench/tb_top.sv
